// ===== rtl/spfas_pkg.sv =====
// ----------------------------------------------------------------------------
// spfas_pkg
// types and constants for the averaged-sample servo pulse generator
// ----------------------------------------------------------------------------
package spfas_pkg;

    typedef struct packed {
        logic       kind;
        logic [9:0] sample;
    } item_t;

    typedef struct packed {
        logic        servo_level;
        logic [12:0] pulse_width;
    } result_t;

    // per-stage control carried along the pipeline
    typedef struct packed {
        logic tick;
        logic done;
    } stage_ctl_t;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_TICK   = 1'b1;

    localparam logic [1:0] CFG_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_SPAN    = 2'd2;

    localparam logic [15:0] PERIOD_RESET = 16'd20000;
    localparam logic [11:0] OFFSET_RESET = 12'd500;
    localparam logic [11:0] SPAN_RESET   = 12'd2000;
    localparam logic [12:0] WIDTH_RESET  = 13'd1500;
    localparam logic [12:0] WIDTH_MAX    = 13'd5000;

    // floor(x / 1023) = (x * ceil(2^32 / 1023)) >> 32, exact for x below 2^22
    localparam logic [22:0] FULL_SCALE_RECIP = 23'd4198405;
    localparam int          FULL_SCALE_SHIFT = 32;

endpackage

// ===== rtl/servo_pulse_from_averaged_sample.sv =====
// ----------------------------------------------------------------------------
// servo_pulse_from_averaged_sample
// averages converter samples into a smoothed pulse width and runs a
// two-phase servo output from microsecond ticks
// ----------------------------------------------------------------------------
// path: an accepted transaction passes stage registers s1 to s5, then the result register
// throughput: one transaction per cycle when not stalled; five register stages
//   carry the mean reciprocal multiply, span multiply and divide-by-1023 multiply
// reset: all but the stage data and result registers load their reset values at once
// ----------------------------------------------------------------------------
module servo_pulse_from_averaged_sample
    import spfas_pkg::*;
#(
    parameter int SAMPLES_AVERAGED = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = $clog2(1023 * SAMPLES_AVERAGED + 1);
    localparam int CW = $clog2(SAMPLES_AVERAGED);
    localparam int RW = SW + 1;
    localparam int MEAN_SHIFT = SW + CW;
    localparam logic [RW-1:0] MEAN_RECIP = RW'(((64'd1 << MEAN_SHIFT)
        + 64'(SAMPLES_AVERAGED) - 64'd1) / 64'(SAMPLES_AVERAGED));
    localparam logic [CW-1:0] COUNT_LAST = CW'(SAMPLES_AVERAGED - 1);

    // configuration
    logic [15:0] period_reg;
    logic [11:0] offset_reg;
    logic [11:0] span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            offset_reg <= OFFSET_RESET;
            span_reg   <= SPAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_OFFSET: offset_reg <= cfg_data[11:0];
                CFG_SPAN:   span_reg   <= cfg_data[11:0];
                default:    ;
            endcase
        end
    end

    // flow control
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic result_valid_reg;
    logic adv_out, rdy5, rdy4, rdy3, rdy2, rdy1, accept, fire5;

    assign adv_out    = !result_valid_reg || !result_stall;
    assign rdy5       = !s5_v_reg || adv_out;
    assign rdy4       = !s4_v_reg || rdy5;
    assign rdy3       = !s3_v_reg || rdy4;
    assign rdy2       = !s2_v_reg || rdy3;
    assign rdy1       = !s1_v_reg || rdy2;
    assign item_stall = !rdy1;
    assign accept     = item_valid && rdy1;
    assign fire5      = s5_v_reg && adv_out;

    // sample accumulation
    logic [SW-1:0] sum_reg, sum_next, total;
    logic [CW-1:0] count_reg, count_next;
    logic          last_sample;
    stage_ctl_t    s1_ctl_next;

    always_comb
    begin
        total       = sum_reg + SW'(item.sample);
        last_sample = (count_reg == COUNT_LAST);
        sum_next    = sum_reg;
        count_next  = count_reg;
        s1_ctl_next.tick = (item.kind == KIND_TICK);
        s1_ctl_next.done = (item.kind == KIND_SAMPLE) && last_sample;
        if (accept && item.kind == KIND_SAMPLE)
        begin
            sum_next   = last_sample ? '0 : total;
            count_next = last_sample ? '0 : count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // pipeline payload
    stage_ctl_t       s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    logic [SW-1:0]    s1_total_reg;
    logic [9:0]       s2_mean_reg, s2_mean_next;
    logic [21:0]      s3_prod_reg, s3_prod_next;
    logic [11:0]      s4_quot_reg, s4_quot_next;
    logic [12:0]      s5_target_reg, s5_target_next;
    logic [SW+RW-1:0] mean_prod;
    logic [44:0]      quot_prod;
    logic [12:0]      target_sum;

    assign mean_prod      = (SW+RW)'(s1_total_reg) * (SW+RW)'(MEAN_RECIP);
    assign s2_mean_next   = mean_prod[MEAN_SHIFT +: 10];
    assign s3_prod_next   = 22'(s2_mean_reg) * 22'(span_reg);
    assign quot_prod      = 45'(s3_prod_reg) * 45'(FULL_SCALE_RECIP);
    assign s4_quot_next   = quot_prod[FULL_SCALE_SHIFT +: 12];
    assign target_sum     = 13'(s4_quot_reg) + 13'(offset_reg);
    assign s5_target_next = (target_sum > WIDTH_MAX) ? WIDTH_MAX : target_sum;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_ctl_reg   <= s1_ctl_next;
            s1_total_reg <= total;
        end
        if (rdy2)
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_mean_reg <= s2_mean_next;
        end
        if (rdy3)
        begin
            s3_ctl_reg  <= s2_ctl_reg;
            s3_prod_reg <= s3_prod_next;
        end
        if (rdy4)
        begin
            s4_ctl_reg  <= s3_ctl_reg;
            s4_quot_reg <= s4_quot_next;
        end
        if (rdy5)
        begin
            s5_ctl_reg    <= s4_ctl_reg;
            s5_target_reg <= s5_target_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            s3_v_reg         <= 1'b0;
            s4_v_reg         <= 1'b0;
            s5_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)    s1_v_reg         <= item_valid;
            if (rdy2)    s2_v_reg         <= s1_v_reg;
            if (rdy3)    s3_v_reg         <= s2_v_reg;
            if (rdy4)    s4_v_reg         <= s3_v_reg;
            if (rdy5)    s5_v_reg         <= s4_v_reg;
            if (adv_out) result_valid_reg <= s5_v_reg;
        end
    end

    // smoothing and phase counter
    logic [12:0] smoothed_reg, smoothed_next, gap, step, moved;
    logic        high_reg, high_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        up;

    always_comb
    begin
        up    = s5_target_reg > smoothed_reg;
        gap   = up ? s5_target_reg - smoothed_reg : smoothed_reg - s5_target_reg;
        step  = gap >> 2;
        if (up)
        begin
            moved = smoothed_reg + step;
            if (moved < s5_target_reg)
            begin
                moved = moved + 13'd1;
            end
        end
        else
        begin
            moved = smoothed_reg - step;
            if (moved > s5_target_reg)
            begin
                moved = moved - 13'd1;
            end
        end

        smoothed_next = smoothed_reg;
        high_next     = high_reg;
        ticks_next    = ticks_reg;
        if (fire5)
        begin
            if (s5_ctl_reg.done)
            begin
                smoothed_next = moved;
            end
            if (s5_ctl_reg.tick)
            begin
                if (ticks_reg == 16'd1)
                begin
                    high_next  = !high_reg;
                    ticks_next = high_reg ? period_reg - 16'(smoothed_reg)
                                          : 16'(smoothed_reg);
                end
                else
                begin
                    ticks_next = ticks_reg - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= WIDTH_RESET;
            high_reg     <= 1'b0;
            ticks_reg    <= PERIOD_RESET;
        end
        else
        begin
            smoothed_reg <= smoothed_next;
            high_reg     <= high_next;
            ticks_reg    <= ticks_next;
        end
    end

    // result register
    result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (fire5)
        begin
            result_reg.servo_level <= high_next;
            result_reg.pulse_width <= smoothed_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        smoothed_reg <= WIDTH_MAX)
        else $error("smoothed width above maximum");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LAST)
        else $error("sample count out of range");

    a_phase_end: assert property (@(posedge clk) disable iff (!rst_n)
        (high_reg != $past(high_reg)) |->
            ($past(ticks_reg) == 16'd1 && $past(fire5) && $past(s5_ctl_reg.tick)))
        else $error("phase changed without phase end");

    a_width_update: assert property (@(posedge clk) disable iff (!rst_n)
        (smoothed_reg != $past(smoothed_reg)) |->
            ($past(fire5) && $past(s5_ctl_reg.done)))
        else $error("smoothed width changed without a completed mean");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)))
        else $error("result overwritten while stalled");

endmodule
